### sv/pgig_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic ghost image generator: widths, shift masks,
// register indexes and the queue entry type. No dependencies.
package pgig_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int POS_W      = FRAC_BITS + 3;
   localparam int GHOST_W    = FRAC_BITS + 4;
   localparam int MASS_W     = 32;
   localparam int CW_W       = FRAC_BITS + 1;
   localparam int Q_W        = FRAC_BITS + 6;
   localparam int SHIFTS     = 27;
   localparam int CENTER     = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CW_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH      = CSR_IDX_W'(1);

   localparam logic [CW_W-1:0] CELL_WIDTH_RESET = CW_W'(1 << (FRAC_BITS - 8));

   localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;
   localparam logic signed [GHOST_W-1:0] ONE_G = GHOST_W'(1) << FRAC_BITS;

   // shift index k = (sz+1)*9 + (sy+1)*3 + (sx+1)
   localparam logic [SHIFTS-1:0] X_NEG_MASK = 27'o111111111;
   localparam logic [SHIFTS-1:0] X_POS_MASK = 27'o444444444;
   localparam logic [SHIFTS-1:0] Y_NEG_MASK = 27'o007007007;
   localparam logic [SHIFTS-1:0] Y_POS_MASK = 27'o700700700;
   localparam logic [SHIFTS-1:0] Z_NEG_MASK = 27'o000000777;
   localparam logic [SHIFTS-1:0] Z_POS_MASK = 27'o777000000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [MASS_W-1:0]       mass;
      logic [SHIFTS-1:0]       mask;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

### sv/pgig_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces for the ghost image generator: particle in, ghost out.
// Depends on pgig_pkg.
interface pgig_req_if;
   import pgig_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [MASS_W-1:0]       mass;
   modport source (output valid, pos_x, pos_y, pos_z, mass, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, mass, output ready);
endinterface

interface pgig_rsp_if;
   import pgig_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [GHOST_W-1:0] ghost_x;
   logic signed [GHOST_W-1:0] ghost_y;
   logic signed [GHOST_W-1:0] ghost_z;
   logic [MASS_W-1:0]         ghost_mass;
   logic                      last_ghost;
   modport source (output valid, ghost_x, ghost_y, ghost_z, ghost_mass, last_ghost,
                   input ready);
   modport sink (input valid, ghost_x, ghost_y, ghost_z, ghost_mass, last_ghost,
                 output ready);
endinterface

### sv/pgig_front.sv
`timescale 1ns / 1ps
// Front end: holds the control registers, accepts particles and builds the
// 27-bit mask of shifts that yield a ghost. Depends on pgig_pkg, pgig_ifs.
module pgig_front (
   input  logic                               clock,
   input  logic                               reset,
   pgig_req_if.sink                           req,
   input  logic                               csr_wr_en,
   input  logic [pgig_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pgig_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pgig_pkg::entry_type                push_data,
   output logic                               push_valid,
   input  logic                               push_ready
);
   import pgig_pkg::*;

   logic            enable_ff, enable_in;
   logic [CW_W-1:0] cell_width_ff, cell_width_in;

   logic signed [Q_W-1:0] lo_bound;
   logic signed [Q_W-1:0] hi_bound;
   logic signed [Q_W-1:0] pos_q [3];
   logic [2:0]            inner [3];
   logic [2:0]            outer [3];
   logic [SHIFTS-1:0]     mask;

   always_comb begin
      enable_in     = enable_ff;
      cell_width_in = cell_width_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PERIODIC_ENABLE: enable_in = csr_wdata[0];
            CSR_CELL_WIDTH:      cell_width_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         cell_width_ff <= CELL_WIDTH_RESET;
      end else begin
         enable_ff     <= enable_in;
         cell_width_ff <= cell_width_in;
      end
   end

   assign lo_bound = -$signed(Q_W'({cell_width_ff, 1'b0}));
   assign hi_bound = ONE_Q + $signed(Q_W'(cell_width_ff));
   assign pos_q[0] = Q_W'(req.pos_x);
   assign pos_q[1] = Q_W'(req.pos_y);
   assign pos_q[2] = Q_W'(req.pos_z);

   always_comb begin
      logic signed [Q_W-1:0] q;
      for (int a = 0; a < 3; a++) begin
         for (int s = 0; s < 3; s++) begin
            if (s == 0) begin
               q = pos_q[a] - ONE_Q;
            end else if (s == 2) begin
               q = pos_q[a] + ONE_Q;
            end else begin
               q = pos_q[a];
            end
            inner[a][s] = (q >= 0) && (q < ONE_Q);
            outer[a][s] = (q >= lo_bound) && (q < hi_bound);
         end
      end
   end

   always_comb begin
      mask = '0;
      for (int sz = 0; sz < 3; sz++) begin
         for (int sy = 0; sy < 3; sy++) begin
            for (int sx = 0; sx < 3; sx++) begin
               mask[sz * 9 + sy * 3 + sx] = outer[0][sx] & outer[1][sy] & outer[2][sz]
                  & ~(inner[0][sx] & inner[1][sy] & inner[2][sz]);
            end
         end
      end
      mask[CENTER] = 1'b0;
   end

   assign req.ready = push_ready;
   assign push_valid = req.valid && enable_ff && (mask != '0);
   assign push_data.pos_x = req.pos_x;
   assign push_data.pos_y = req.pos_y;
   assign push_data.pos_z = req.pos_z;
   assign push_data.mass  = req.mass;
   assign push_data.mask  = mask;

endmodule

### sv/pgig_queue.sv
`timescale 1ns / 1ps
// Short queue of classified particles between front and back end.
// Depends on pgig_pkg.
module pgig_queue (
   input  logic                clock,
   input  logic                reset,
   input  pgig_pkg::entry_type push_data,
   input  logic                push_valid,
   output logic                push_ready,
   output pgig_pkg::entry_type pop_data,
   output pgig_pkg::hs_type    pop_hs,
   input  logic                pop_take
);
   import pgig_pkg::*;

   entry_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_hs.valid = (count_ff != '0);
   assign pop_hs.ready = pop_take;
   assign pop_data     = slots_ff[rd_ptr_ff];
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop_take && pop_hs.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/pgig_back.sv
`timescale 1ns / 1ps
// Back end: walks the shift mask of the current particle, one ghost a cycle
// while the output register is free, into that register. Depends on pgig_pkg, pgig_ifs.
module pgig_back (
   input  logic                clock,
   input  logic                reset,
   input  pgig_pkg::entry_type pop_data,
   input  pgig_pkg::hs_type    pop_hs,
   output logic                pop_take,
   pgig_rsp_if.source          rsp
);
   import pgig_pkg::*;

   entry_type                 cur_ff, cur_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [GHOST_W-1:0] gx_ff, gy_ff, gz_ff;
   logic [MASS_W-1:0]         gmass_ff;
   logic                      glast_ff;

   logic                      out_free;
   logic                      emit;
   logic                      emit_last;
   logic                      load;
   logic [SHIFTS-1:0]         low_bit;
   logic [SHIFTS-1:0]         mask_rest;
   logic signed [GHOST_W-1:0] gx, gy, gz;

   function automatic logic signed [GHOST_W-1:0] shift_coord(
      input logic signed [POS_W-1:0] p,
      input logic                    neg,
      input logic                    pos
   );
      logic signed [GHOST_W-1:0] base;
      base = GHOST_W'(p);
      if (neg) begin
         return base - ONE_G;
      end else if (pos) begin
         return base + ONE_G;
      end
      return base;
   endfunction

   assign out_free  = !out_valid_ff || rsp.ready;
   assign emit      = cur_valid_ff && out_free;
   assign low_bit   = cur_ff.mask & (~cur_ff.mask + 1'b1);
   assign mask_rest = cur_ff.mask & ~low_bit;
   assign emit_last = emit && (mask_rest == '0);
   assign load      = pop_hs.valid && (!cur_valid_ff || emit_last);
   assign pop_take  = load;

   assign gx = shift_coord(cur_ff.pos_x, |(low_bit & X_NEG_MASK), |(low_bit & X_POS_MASK));
   assign gy = shift_coord(cur_ff.pos_y, |(low_bit & Y_NEG_MASK), |(low_bit & Y_POS_MASK));
   assign gz = shift_coord(cur_ff.pos_z, |(low_bit & Z_NEG_MASK), |(low_bit & Z_POS_MASK));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (load) begin
         cur_in       = pop_data;
         cur_valid_in = 1'b1;
      end else if (emit_last) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         cur_in.mask = mask_rest;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         gx_ff    <= gx;
         gy_ff    <= gy;
         gz_ff    <= gz;
         gmass_ff <= cur_ff.mass;
         glast_ff <= (mask_rest == '0);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.ghost_x    = gx_ff;
   assign rsp.ghost_y    = gy_ff;
   assign rsp.ghost_z    = gz_ff;
   assign rsp.ghost_mass = gmass_ff;
   assign rsp.last_ghost = glast_ff;

   a_cur_mask_live: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.mask != '0) && !cur_ff.mask[CENTER])
      else $error("active particle without pending shifts");

   a_emit_onehot: assert property (@(posedge clock) disable iff (reset)
      emit |-> $onehot(low_bit))
      else $error("shift select not one-hot");

   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      load |=> cur_valid_ff)
      else $error("loaded particle dropped");

   a_emit_continue: assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> cur_valid_ff && out_valid_ff)
      else $error("particle ended before its last ghost");

endmodule

### sv/periodic_ghost_image_generator_unit.sv
`timescale 1ns / 1ps
// Particles enter at one per cycle whenever the four-word particle queue has
// room; interior particles and particles seen with periodic mode off leave no
// trace. A particle that has ghosts (1 to 26 of them) occupies the back end
// until its last ghost is out, since the back end walks the shift mask one bit
// a cycle into the output register while that register is free; the queue
// lets new particles be accepted while earlier ghosts drain. Write the
// registers only while the block is idle.
// Top level; depends on pgig_pkg, pgig_ifs, pgig_front, pgig_queue, pgig_back.
module periodic_ghost_image_generator_unit (
   input  logic                            clock,
   input  logic                            reset,
   pgig_req_if.sink                        req,
   pgig_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [pgig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pgig_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pgig_pkg::*;

   entry_type push_data;
   logic      push_valid;
   logic      push_ready;
   entry_type pop_data;
   hs_type    pop_hs;
   logic      pop_take;

   pgig_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   pgig_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_hs     (pop_hs),
      .pop_take   (pop_take)
   );

   pgig_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .pop_hs   (pop_hs),
      .pop_take (pop_take),
      .rsp      (rsp)
   );

endmodule
